FILE: design/mffd_pkg.sv
// Shared types and constants for the motor feedback frame decoder.
package mffd_pkg;

	// Field widths
	localparam int unsigned CODE_W  = 16;   // widest raw code
	localparam int unsigned LIMIT_W = 24;   // full-scale limit registers
	localparam int unsigned QUOT_W  = LIMIT_W + 1;           // quotient, at most 2*limit
	localparam int unsigned NUM_W   = CODE_W + LIMIT_W + 1;  // 2 * code * limit
	localparam int unsigned TPROD_W = 16 + LIMIT_W + 2;      // turn * 2 * limit, signed
	localparam int unsigned LANES   = 3;    // position, velocity, torque
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = LIMIT_W;

	// Code widths
	localparam int unsigned POSITION_BITS_DEF = 16;
	localparam int unsigned VELOCITY_BITS_DEF = 12;
	localparam int unsigned TORQUE_BITS       = 12;

	localparam logic signed [15:0] TURN_MAX = 16'sd32767;
	localparam logic [6:0]         MIN_LEN  = 7'd8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUS_SELECT     = 3'd0,
		CFG_MOTOR_ID       = 3'd1,
		CFG_FEEDBACK_ID    = 3'd2,
		CFG_REVERSE_DIR    = 3'd3,
		CFG_POSITION_LIMIT = 3'd4,
		CFG_VELOCITY_LIMIT = 3'd5,
		CFG_TORQUE_LIMIT   = 3'd6
	} cfg_reg_t;

	// Reset values of the configuration registers
	localparam logic [1:0]         BUS_SELECT_RST     = 2'd0;
	localparam logic [3:0]         MOTOR_ID_RST       = 4'd1;
	localparam logic [10:0]        FEEDBACK_ID_RST    = 11'd0;
	localparam logic               REVERSE_DIR_RST    = 1'b0;
	localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST = 24'd819200;
	localparam logic [LIMIT_W-1:0] VELOCITY_LIMIT_RST = 24'd1966080;
	localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST   = 24'd655360;

	// Fields that ride along the scaling pipeline
	typedef struct packed {
		logic [3:0]                 status;
		logic [7:0]                 driver_temp;
		logic [7:0]                 rotor_temp;
		logic signed [15:0]         turn;
		logic signed [TPROD_W-1:0]  tprod;
	} side_t;

endpackage

FILE: design/motor_feedback_frame_decoder.sv
// Motor feedback frame decoder: frame filter, turn tracking and Q8.16 scaling pipeline.
// Pipeline: input register, products, one fold stage per fold (FOLDS), remainder
// correction and output register; FOLDS is set by the narrowest code width.
// Throughput: one beat per cycle unless out_ready stalls the output; every stage moves
// on its own, so input is taken while a result waits until every stage holds a beat.
// Rejected frames and zero actions make no result.
// Reset: arst_n clears pipeline valids and turn tracking, and loads the
// configuration registers with their default values.
module motor_feedback_frame_decoder
	import mffd_pkg::*;
#(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	parameter int unsigned VELOCITY_BITS = VELOCITY_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [1:0]            bus_index,
	input  logic [10:0]           frame_id,
	input  logic [6:0]            frame_len,
	input  logic [7:0]            data_byte0,
	input  logic [7:0]            data_byte1,
	input  logic [7:0]            data_byte2,
	input  logic [7:0]            data_byte3,
	input  logic [7:0]            data_byte4,
	input  logic [7:0]            data_byte5,
	input  logic [7:0]            data_byte6,
	input  logic [7:0]            data_byte7,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [3:0]            motor_status,
	output logic signed [24:0]    position_out,
	output logic signed [47:0]    total_position_out,
	output logic signed [15:0]    turn_count_out,
	output logic signed [24:0]    velocity_out,
	output logic signed [24:0]    torque_out,
	output logic [7:0]            driver_temp,
	output logic [7:0]            rotor_temp
);

	// Each fold removes about n-1 bits from the numerator; two more settle it below 2^n.
	localparam int unsigned NMIN0 = (POSITION_BITS < VELOCITY_BITS) ? POSITION_BITS
		: VELOCITY_BITS;
	localparam int unsigned NMIN  = (NMIN0 < TORQUE_BITS) ? NMIN0 : TORQUE_BITS;
	localparam int unsigned FOLDS = (QUOT_W + NMIN - 2) / (NMIN - 1) + 2;

	localparam logic [CODE_W-1:0] PMASK = CODE_W'((32'd1 << POSITION_BITS) - 32'd1);
	localparam logic [11:0]       VMASK = 12'((32'd1 << VELOCITY_BITS) - 32'd1);
	localparam logic signed [CODE_W:0] HALF =
		(CODE_W + 1)'(32'd1 << (POSITION_BITS - 1));

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [1:0]         bus_sel_q;
	logic [3:0]         motor_id_q;
	logic [10:0]        fb_id_q;
	logic               rev_q;
	logic [LIMIT_W-1:0] pos_lim_q;
	logic [LIMIT_W-1:0] vel_lim_q;
	logic [LIMIT_W-1:0] tor_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_sel_q  <= BUS_SELECT_RST;
			motor_id_q <= MOTOR_ID_RST;
			fb_id_q    <= FEEDBACK_ID_RST;
			rev_q      <= REVERSE_DIR_RST;
			pos_lim_q  <= POSITION_LIMIT_RST;
			vel_lim_q  <= VELOCITY_LIMIT_RST;
			tor_lim_q  <= TORQUE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BUS_SELECT:     bus_sel_q  <= cfg_data[1:0];
				CFG_MOTOR_ID:       motor_id_q <= cfg_data[3:0];
				CFG_FEEDBACK_ID:    fb_id_q    <= cfg_data[10:0];
				CFG_REVERSE_DIR:    rev_q      <= cfg_data[0];
				CFG_POSITION_LIMIT: pos_lim_q  <= cfg_data;
				CFG_VELOCITY_LIMIT: vel_lim_q  <= cfg_data;
				CFG_TORQUE_LIMIT:   tor_lim_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [LIMIT_W-1:0] lane_lim [LANES];
	assign lane_lim[0] = pos_lim_q;
	assign lane_lim[1] = vel_lim_q;
	assign lane_lim[2] = tor_lim_q;

	// ---------------------------------------------------------------
	// Stage flow control: a stage loads when it is empty or moves on
	// ---------------------------------------------------------------
	logic             vld_s1, vld_s2, vld_s4, vld_s5;
	logic [FOLDS-1:0] vld_s3;
	logic             adv_s1, adv_s2, adv_s4, adv_s5;
	logic [FOLDS-1:0] adv_s3;

	assign adv_s5   = !vld_s5 || out_ready;
	assign adv_s4   = !vld_s4 || adv_s5;
	assign adv_s2   = !vld_s2 || adv_s3[0];
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic        act_s1;
	logic [1:0]  bus_s1;
	logic [10:0] id_s1;
	logic [6:0]  len_s1;
	logic [7:0]  b0_s1, b1_s1, b2_s1, b3_s1, b4_s1, b5_s1, b6_s1, b7_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			act_s1 <= action;
			bus_s1 <= bus_index;
			id_s1  <= frame_id;
			len_s1 <= frame_len;
			b0_s1  <= data_byte0;
			b1_s1  <= data_byte1;
			b2_s1  <= data_byte2;
			b3_s1  <= data_byte3;
			b4_s1  <= data_byte4;
			b5_s1  <= data_byte5;
			b6_s1  <= data_byte6;
			b7_s1  <= data_byte7;
		end
	end

	// ---------------------------------------------------------------
	// Frame filter and turn tracking
	// ---------------------------------------------------------------
	logic                track_q;
	logic [CODE_W-1:0]   prev_code_q;
	logic signed [15:0]  turn_q;

	logic                match;
	logic                fire_s1;
	logic [CODE_W-1:0]   pcode;
	logic signed [CODE_W:0] diff;
	logic signed [15:0]  turn_step;
	logic signed [15:0]  turn_new;

	assign fire_s1 = vld_s1 && adv_s2;
	assign match   = !act_s1 && (len_s1 >= MIN_LEN) && (bus_s1 == bus_sel_q)
		&& (id_s1 == fb_id_q) && (b0_s1[3:0] == motor_id_q);
	assign pcode   = {b1_s1, b2_s1} & PMASK;
	assign diff    = $signed({1'b0, pcode}) - $signed({1'b0, prev_code_q});

	// Forward jump of half a turn or more is a backward wrap, and vice versa
	always_comb begin
		turn_step = turn_q;
		if (diff >= HALF) begin
			if (turn_q > -TURN_MAX) turn_step = turn_q - 16'sd1;
		end else if (diff <= -HALF) begin
			if (turn_q < TURN_MAX) turn_step = turn_q + 16'sd1;
		end
		turn_new = track_q ? turn_step : turn_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q     <= 1'b0;
			prev_code_q <= '0;
			turn_q      <= '0;
		end else if (fire_s1) begin
			if (act_s1) begin
				track_q     <= 1'b0;
				prev_code_q <= '0;
				turn_q      <= '0;
			end else if (match) begin
				track_q     <= 1'b1;
				prev_code_q <= pcode;
				turn_q      <= turn_new;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: products 2*code*limit and turn*2*limit
	// ---------------------------------------------------------------
	logic [CODE_W-1:0]  lane_code [LANES];
	logic [NUM_W-1:0]   num_s2 [LANES];
	side_t              side_s2;
	logic signed [TPROD_W-2:0] tp;

	assign lane_code[0] = pcode;
	assign lane_code[1] = CODE_W'({b3_s1, b4_s1[7:4]} & VMASK);
	assign lane_code[2] = CODE_W'({b4_s1[3:0], b5_s1});
	assign tp = (TPROD_W - 1)'(turn_new) * (TPROD_W - 1)'($signed({1'b0, pos_lim_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1 && match;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			side_s2.status      <= b0_s1[7:4];
			side_s2.driver_temp <= b6_s1;
			side_s2.rotor_temp  <= b7_s1;
			side_s2.turn        <= turn_new;
			side_s2.tprod       <= {tp, 1'b0};
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_mul
		logic [NUM_W-2:0] prod;
		assign prod = (NUM_W - 1)'(lane_code[l]) * (NUM_W - 1)'(lane_lim[l]);
		always_ff @(posedge clk) begin
			if (adv_s2) num_s2[l] <= {prod, 1'b0};
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: division by 2^n-1, one fold per stage
	// fold: q += v >> n; v = (v >> n) + (v & (2^n-1)); index k is stage 3+k
	// ---------------------------------------------------------------
	logic [NUM_W-1:0]  fv_s3 [FOLDS][LANES];
	logic [QUOT_W-1:0] fq_s3 [FOLDS][LANES];
	side_t             side_s3 [FOLDS];

	for (genvar f = 0; f < FOLDS; f++) begin : g_fold
		logic [NUM_W-1:0]  v_in [LANES];
		logic [QUOT_W-1:0] q_in [LANES];
		side_t             side_in;
		logic              vld_in;
		logic              adv_nxt;

		if (f == 0) begin : g_first
			// reverse applied to the turn term here, ahead of the final sum
			always_comb begin
				vld_in        = vld_s2;
				side_in       = side_s2;
				side_in.tprod = rev_q ? -side_s2.tprod : side_s2.tprod;
			end
			for (genvar l = 0; l < LANES; l++) begin : g_ld
				assign v_in[l] = num_s2[l];
				assign q_in[l] = '0;
			end
		end else begin : g_next
			assign vld_in  = vld_s3[f-1];
			assign side_in = side_s3[f-1];
			for (genvar l = 0; l < LANES; l++) begin : g_ld
				assign v_in[l] = fv_s3[f-1][l];
				assign q_in[l] = fq_s3[f-1][l];
			end
		end

		if (f == FOLDS - 1) begin : g_last
			assign adv_nxt = adv_s4;
		end else begin : g_mid
			assign adv_nxt = adv_s3[f+1];
		end

		assign adv_s3[f] = !vld_s3[f] || adv_nxt;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[f] <= 1'b0;
			end else if (adv_s3[f]) begin
				vld_s3[f] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv_s3[f]) side_s3[f] <= side_in;
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			localparam int unsigned N = (l == 0) ? POSITION_BITS
				: (l == 1) ? VELOCITY_BITS : TORQUE_BITS;
			localparam logic [NUM_W-1:0] D = NUM_W'((64'd1 << N) - 64'd1);
			logic [NUM_W-1:0] hi;
			assign hi = v_in[l] >> N;
			always_ff @(posedge clk) begin
				if (adv_s3[f]) begin
					fv_s3[f][l] <= hi + (v_in[l] & D);
					fq_s3[f][l] <= q_in[l] + QUOT_W'(hi);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: remainder correction, offset by limit, direction
	// ---------------------------------------------------------------
	logic signed [24:0] sc_s4 [LANES];
	side_t              side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv_s4) begin
			vld_s4 <= vld_s3[FOLDS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) side_s4 <= side_s3[FOLDS-1];
	end

	for (genvar l = 0; l < LANES; l++) begin : g_fin
		localparam int unsigned N = (l == 0) ? POSITION_BITS
			: (l == 1) ? VELOCITY_BITS : TORQUE_BITS;
		localparam logic [NUM_W-1:0] D = NUM_W'((64'd1 << N) - 64'd1);
		logic [QUOT_W-1:0]  qf;
		logic signed [25:0] val;
		// leftover equal to the divisor is one more whole quotient step
		assign qf  = fq_s3[FOLDS-1][l] + QUOT_W'(fv_s3[FOLDS-1][l] == D);
		assign val = $signed({1'b0, qf}) - $signed({2'b00, lane_lim[l]});
		always_ff @(posedge clk) begin
			if (adv_s4) sc_s4[l] <= rev_q ? 25'(-val) : 25'(val);
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: multi-turn sum and output register
	// ---------------------------------------------------------------
	logic signed [24:0] pos_s5, vel_s5, tor_s5;
	logic signed [47:0] total_s5;
	side_t              side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv_s5) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			pos_s5   <= sc_s4[0];
			vel_s5   <= sc_s4[1];
			tor_s5   <= sc_s4[2];
			total_s5 <= 48'(sc_s4[0]) + 48'(side_s4.tprod);
			side_s5  <= side_s4;
		end
	end

	assign out_valid          = vld_s5;
	assign motor_status       = side_s5.status;
	assign position_out       = pos_s5;
	assign total_position_out = total_s5;
	assign turn_count_out     = side_s5.turn;
	assign velocity_out       = vel_s5;
	assign torque_out         = tor_s5;
	assign driver_temp        = side_s5.driver_temp;
	assign rotor_temp         = side_s5.rotor_temp;

`ifndef SYNTHESIS
	// Turn count never reaches the most negative code
	a_turn_sat: assert property (@(posedge clk) disable iff (!arst_n)
		turn_q != -16'sd32768)
		else $error("turn count left saturation range");

	// A zero action leaving stage 1 clears tracking
	a_zero_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && act_s1 && adv_s2) |=> (!track_q && turn_q == 16'sd0))
		else $error("zero action did not clear tracking");

	// With no whole turns the multi-turn position equals the single-turn one
	a_total_no_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && side_s5.turn == 16'sd0) |-> (total_s5 == 48'(pos_s5)))
		else $error("total position differs from position at zero turns");

	// Scaled velocity stays within its full scale
	a_vel_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (vel_s5 <= $signed({1'b0, vel_lim_q})
			&& vel_s5 >= -$signed({1'b0, vel_lim_q})))
		else $error("velocity outside full scale");
`endif

endmodule

FILE: test/tb_motor_feedback_frame_decoder.sv
// Testbench for the motor feedback frame decoder: random frames, turn tracking and scaling checks.
`timescale 1ns / 1ps

module tb_motor_feedback_frame_decoder
	import mffd_pkg::*;
();

	localparam int unsigned POS_BITS    = POSITION_BITS_DEF;
	localparam int unsigned VEL_BITS    = VELOCITY_BITS_DEF;
	localparam int          DRAIN_PAD   = 24;       // well past the pipeline latency
	localparam int          CYCLE_LIMIT = 1000000;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

	// One input beat
	typedef struct packed {
		logic            action;
		logic [1:0]      bus;
		logic [10:0]     id;
		logic [6:0]      len;
		logic [7:0][7:0] data;
	} frame_t;

	// One decoded feedback beat
	typedef struct packed {
		logic [3:0]         status;
		logic signed [24:0] pos;
		logic signed [47:0] total;
		logic signed [15:0] turns;
		logic signed [24:0] vel;
		logic signed [24:0] tq;
		logic [7:0]         dtemp;
		logic [7:0]         rtemp;
	} feedback_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = 1'b0;
	logic [1:0]  bus_index = '0;
	logic [10:0] frame_id = '0;
	logic [6:0]  frame_len = '0;
	logic [7:0]  data_byte0 = '0, data_byte1 = '0, data_byte2 = '0, data_byte3 = '0;
	logic [7:0]  data_byte4 = '0, data_byte5 = '0, data_byte6 = '0, data_byte7 = '0;

	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [3:0]         motor_status;
	logic signed [24:0] position_out;
	logic signed [47:0] total_position_out;
	logic signed [15:0] turn_count_out;
	logic signed [24:0] velocity_out;
	logic signed [24:0] torque_out;
	logic [7:0]         driver_temp;
	logic [7:0]         rotor_temp;

	motor_feedback_frame_decoder #(
		.POSITION_BITS(POS_BITS),
		.VELOCITY_BITS(VEL_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.bus_index(bus_index), .frame_id(frame_id), .frame_len(frame_len),
		.data_byte0(data_byte0), .data_byte1(data_byte1), .data_byte2(data_byte2),
		.data_byte3(data_byte3), .data_byte4(data_byte4), .data_byte5(data_byte5),
		.data_byte6(data_byte6), .data_byte7(data_byte7),
		.out_valid(out_valid), .out_ready(out_ready), .motor_status(motor_status),
		.position_out(position_out), .total_position_out(total_position_out),
		.turn_count_out(turn_count_out), .velocity_out(velocity_out),
		.torque_out(torque_out), .driver_temp(driver_temp), .rotor_temp(rotor_temp)
	);

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mirror of the configuration registers
	logic [1:0]         cfg_bus = BUS_SELECT_RST;
	logic [3:0]         cfg_motor = MOTOR_ID_RST;
	logic [10:0]        cfg_fid = FEEDBACK_ID_RST;
	logic               cfg_rev = REVERSE_DIR_RST;
	logic [LIMIT_W-1:0] cfg_plim = POSITION_LIMIT_RST;
	logic [LIMIT_W-1:0] cfg_vlim = VELOCITY_LIMIT_RST;
	logic [LIMIT_W-1:0] cfg_tlim = TORQUE_LIMIT_RST;

	// Turn tracking state of the predictor
	bit          trk_valid = 1'b0;
	logic [15:0] prev_code = '0;
	int          turns = 0;

	frame_t    frame_q[$];
	feedback_t feedback_q[$];
	int        mismatches = 0;
	int        cycles = 0;
	logic      in_taken = 1'b0;
	int        src_rate = 6;     // 1-in-N chance of a gap burst, 0 = none
	int        sink_rate = 6;
	int        src_gap = 0;
	int        sink_stall = 0;
	logic [15:0] last_code = '0;

	// floor(code * 2 * limit / (2^bits - 1)) - limit
	function automatic longint scale_code(input logic [15:0] code, input logic [LIMIT_W-1:0] lim,
			input int unsigned bits);
		longint unsigned den, num;
		den = (64'd1 << bits) - 64'd1;
		num = (64'(code) & den) * 64'd2 * 64'(lim);
		return longint'(num / den) - longint'(64'(lim));
	endfunction

	// Filter, track turns and scale one beat; returns 1 when a feedback beat follows
	function automatic bit decode_frame(input frame_t f, output feedback_t r);
		logic [15:0] pcode, vcode, tcode;
		longint pos, total, vel, tq, d;
		r = '0;
		if (f.action) begin
			trk_valid = 1'b0;
			prev_code = '0;
			turns = 0;
			return 1'b0;
		end
		if (f.len < MIN_LEN || f.bus != cfg_bus || f.id != cfg_fid || f.data[0][3:0] != cfg_motor)
			return 1'b0;
		pcode = {f.data[1], f.data[2]} & 16'((32'd1 << POS_BITS) - 1);
		vcode = {4'd0, f.data[3], f.data[4][7:4]};
		tcode = {4'd0, f.data[4][3:0], f.data[5]};
		if (!trk_valid) begin
			trk_valid = 1'b1;
		end else begin
			d = longint'(64'(pcode)) - longint'(64'(prev_code));
			if (d >= (longint'(1) << (POS_BITS - 1))) begin
				if (turns > -int'(TURN_MAX)) turns--;
			end else if (d <= -(longint'(1) << (POS_BITS - 1))) begin
				if (turns < int'(TURN_MAX)) turns++;
			end
		end
		prev_code = pcode;
		pos = scale_code(pcode, cfg_plim, POS_BITS);
		total = pos + longint'(turns) * 2 * longint'(64'(cfg_plim));
		vel = scale_code(vcode, cfg_vlim, VEL_BITS);
		tq = scale_code(tcode, cfg_tlim, TORQUE_BITS);
		if (cfg_rev) begin
			pos = -pos;
			total = -total;
			vel = -vel;
			tq = -tq;
		end
		r.status = f.data[0][7:4];
		r.pos = pos[24:0];
		r.total = total[47:0];
		r.turns = turns[15:0];
		r.vel = vel[24:0];
		r.tq = tq[24:0];
		r.dtemp = f.data[6];
		r.rtemp = f.data[7];
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			if (mismatches < 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Register mirror, prediction on input beats, checking on output beats
	always @(posedge clk) begin
		frame_t    f;
		feedback_t r, want;
		if (!arst_n) begin
			cfg_bus = BUS_SELECT_RST;
			cfg_motor = MOTOR_ID_RST;
			cfg_fid = FEEDBACK_ID_RST;
			cfg_rev = REVERSE_DIR_RST;
			cfg_plim = POSITION_LIMIT_RST;
			cfg_vlim = VELOCITY_LIMIT_RST;
			cfg_tlim = TORQUE_LIMIT_RST;
			trk_valid = 1'b0;
			prev_code = '0;
			turns = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_BUS_SELECT:     cfg_bus = cfg_data[1:0];
					CFG_MOTOR_ID:       cfg_motor = cfg_data[3:0];
					CFG_FEEDBACK_ID:    cfg_fid = cfg_data[10:0];
					CFG_REVERSE_DIR:    cfg_rev = cfg_data[0];
					CFG_POSITION_LIMIT: cfg_plim = cfg_data;
					CFG_VELOCITY_LIMIT: cfg_vlim = cfg_data;
					CFG_TORQUE_LIMIT:   cfg_tlim = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				f.action = action;
				f.bus = bus_index;
				f.id = frame_id;
				f.len = frame_len;
				f.data = {data_byte7, data_byte6, data_byte5, data_byte4,
					data_byte3, data_byte2, data_byte1, data_byte0};
				if (decode_frame(f, r))
					feedback_q.push_back(r);
			end
			if (out_valid && out_ready) begin
				if (feedback_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected feedback beat: status %0d position %0d turns %0d",
							motor_status, position_out, turn_count_out);
					mismatches++;
				end else begin
					want = feedback_q.pop_front();
					check_field("motor_status", want.status, motor_status);
					check_field("position_out", want.pos, position_out);
					check_field("total_position_out", want.total, total_position_out);
					check_field("turn_count_out", want.turns, turn_count_out);
					check_field("velocity_out", want.vel, velocity_out);
					check_field("torque_out", want.tq, torque_out);
					check_field("driver_temp", want.dtemp, driver_temp);
					check_field("rotor_temp", want.rtemp, rotor_temp);
				end
			end
		end
		in_taken <= arst_n && in_valid && in_ready;
	end

	// Frame driver with random gap bursts
	always @(negedge clk) begin
		frame_t f;
		if (arst_n && (!in_valid || in_taken)) begin
			if (src_gap != 0) begin
				src_gap--;
				in_valid <= 1'b0;
			end else if (src_rate != 0 && $urandom_range(0, src_rate - 1) == 0) begin
				src_gap = $urandom_range(0, 10);
				in_valid <= 1'b0;
			end else if (frame_q.size() != 0) begin
				f = frame_q.pop_front();
				action <= f.action;
				bus_index <= f.bus;
				frame_id <= f.id;
				frame_len <= f.len;
				data_byte0 <= f.data[0];
				data_byte1 <= f.data[1];
				data_byte2 <= f.data[2];
				data_byte3 <= f.data[3];
				data_byte4 <= f.data[4];
				data_byte5 <= f.data[5];
				data_byte6 <= f.data[6];
				data_byte7 <= f.data[7];
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result sink with random stall bursts
	always @(negedge clk) begin
		if (sink_stall != 0) begin
			sink_stall--;
			out_ready <= 1'b0;
		end else if (sink_rate != 0 && $urandom_range(0, sink_rate - 1) == 0) begin
			sink_stall = $urandom_range(0, 10);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Frame that passes the filter under the current settings, random content
	function automatic frame_t make_frame(input logic [15:0] pcode);
		frame_t f;
		f.action = 1'b0;
		f.bus = cfg_bus;
		f.id = cfg_fid;
		f.len = 7'($urandom_range(8, 64));
		for (int i = 0; i < 8; i++)
			f.data[i] = 8'($urandom);
		f.data[0][3:0] = cfg_motor;
		{f.data[1], f.data[2]} = pcode;
		return f;
	endfunction

	function automatic frame_t noise_frame();
		frame_t f;
		f.action = 1'b0;
		f.bus = 2'($urandom);
		f.id = 11'($urandom);
		f.len = 7'($urandom_range(0, 64));
		for (int i = 0; i < 8; i++)
			f.data[i] = 8'($urandom);
		return f;
	endfunction

	// fill: 0 = all zero content, 1 = all ones and longest frame, else random
	task automatic push_coded(input logic [15:0] pcode, input int fill);
		frame_t f;
		f = make_frame(pcode);
		if (fill == 0) begin
			f.data[0][7:4] = 4'h0;
			for (int i = 3; i < 8; i++) f.data[i] = 8'h00;
		end else if (fill == 1) begin
			f.data[0][7:4] = 4'hF;
			for (int i = 3; i < 8; i++) f.data[i] = 8'hFF;
			f.len = 7'd64;
		end
		frame_q.push_back(f);
		last_code = pcode;
	endtask

	task automatic push_zero();
		frame_t f;
		f = noise_frame();
		f.action = 1'b1;
		frame_q.push_back(f);
	endtask

	// Mostly well-formed frames with wrap-prone codes, plus zeroing, noise and near misses
	task automatic push_random(input int n);
		frame_t f;
		int kind, kept;
		logic [15:0] pcode;
		kept = 0;
		while (kept < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 6) begin
				push_zero();
				kept++;
			end else if (kind < 16) begin
				frame_q.push_back(noise_frame());
			end else if (kind < 26) begin
				f = make_frame(16'($urandom));
				case ($urandom_range(0, 3))
					0: f.len = 7'($urandom_range(0, 7));
					1: f.bus = cfg_bus + 2'($urandom_range(1, 3));
					2: f.id = cfg_fid ^ 11'($urandom_range(1, 2047));
					default: f.data[0][3:0] = cfg_motor ^ 4'($urandom_range(1, 15));
				endcase
				frame_q.push_back(f);
			end else begin
				case ($urandom_range(0, 5))
					0: pcode = 16'($urandom);
					1, 2: pcode = last_code + 16'($urandom_range(0, 3000)) - 16'd1500;
					3: pcode = last_code + 16'h8000;
					4: pcode = last_code + 16'($urandom_range(32769, 65535));
					default: pcode = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				endcase
				push_coded(pcode, 2);
				kept++;
			end
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [1:0] bus, input logic [3:0] motor, input logic [10:0] fid,
			input logic rev, input logic [LIMIT_W-1:0] pl, input logic [LIMIT_W-1:0] vl,
			input logic [LIMIT_W-1:0] tl);
		write_reg(CFG_BUS_SELECT, CFG_DATA_W'(bus));
		write_reg(CFG_MOTOR_ID, CFG_DATA_W'(motor));
		write_reg(CFG_FEEDBACK_ID, CFG_DATA_W'(fid));
		write_reg(CFG_REVERSE_DIR, CFG_DATA_W'(rev));
		write_reg(CFG_POSITION_LIMIT, pl);
		write_reg(CFG_VELOCITY_LIMIT, vl);
		write_reg(CFG_TORQUE_LIMIT, tl);
	endtask

	// Sender holds off until every queued frame is taken and every result is in
	task automatic wait_drained();
		while (frame_q.size() != 0 || in_valid || feedback_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	function automatic logic [LIMIT_W-1:0] random_limit();
		case ($urandom_range(0, 3))
			0: return LIMIT_W'($urandom_range(1, 255));
			1: return LIMIT_MAX;
			default: return LIMIT_W'($urandom_range(1, 16777215));
		endcase
	endfunction

	function automatic int random_rate();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 4;
			2: return 10;
			default: return 25;
		endcase
	endfunction

	// Stimulus sequence
	initial begin
		frame_t f;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: code extremes, wrap thresholds, rejects, zeroing, length bounds
		push_coded(16'h0000, 0);    // first frame after reset
		push_coded(16'hFFFF, 1);    // full-scale jump up: one turn down
		push_coded(16'h0000, 2);    // full-scale drop: one turn up
		push_coded(16'h8000, 2);    // jump of exactly half
		push_coded(16'h0000, 2);    // drop of exactly half
		push_coded(16'h7FFF, 2);    // just under half: no turn
		push_coded(16'h0000, 2);
		f = make_frame(16'h1234);
		f.len = 7'd7;
		frame_q.push_back(f);
		f.len = 7'd0;
		frame_q.push_back(f);
		f = make_frame(16'h4321);
		f.bus = cfg_bus + 2'd1;
		frame_q.push_back(f);
		f = make_frame(16'h4321);
		f.id = cfg_fid ^ 11'h400;
		frame_q.push_back(f);
		f = make_frame(16'h4321);
		f.data[0][3:0] = cfg_motor ^ 4'h8;
		frame_q.push_back(f);
		push_coded(16'h9000, 2);
		push_zero();
		push_coded(16'hC000, 2);    // first frame after zeroing
		f = make_frame(16'h4000);
		f.len = 7'd8;
		frame_q.push_back(f);
		f = make_frame(16'h4000);
		f.len = 7'd64;
		frame_q.push_back(f);
		wait_drained();

		// Zero limit registers: every scaled output is zero
		set_config(2'd2, 4'd5, 11'h2AA, 1'b1, '0, '0, '0);
		push_random(20);
		wait_drained();

		// Extremes of every register, then random settings
		for (int phase = 0; phase < 8; phase++) begin
			src_rate = random_rate();
			sink_rate = random_rate();
			if (phase == 0)
				set_config(2'd3, 4'd15, 11'h7FF, 1'b1, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
			else if (phase == 1)
				set_config(2'd0, 4'd0, 11'h000, 1'b0, 24'd1, 24'd1, 24'd1);
			else
				set_config(2'($urandom), 4'($urandom), 11'($urandom), 1'($urandom),
					random_limit(), random_limit(), random_limit());
			push_random(150);
			wait_drained();
		end

		// Last part, no idling: back-to-back runs of half-scale wraps in each direction
		src_rate = 0;
		sink_rate = 0;
		set_config(2'd1, 4'd3, 11'h155, 1'b0, LIMIT_MAX, random_limit(), random_limit());
		push_zero();
		for (int k = 0; k < 8; k++) begin
			push_coded(16'(k), 2);
			push_coded(16'(k + 32768), 2);    // half-scale jump up: one turn down
		end
		wait_drained();
		write_reg(CFG_REVERSE_DIR, CFG_DATA_W'(1));
		push_zero();
		push_coded(16'hFFFF, 2);
		for (int k = 0; k < 8; k++) begin
			push_coded(16'(32767 - k), 2);    // half-scale drop: one turn up
			push_coded(16'(65534 - k), 2);
		end
		wait_drained();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
